@@ sv/spq_pkg.sv @@
// Shared types and codes for the sorted priority queue.
// Used by the cell and the top level; depends on nothing else.
package spq_pkg;

    localparam int unsigned VALUE_W = 16;
    localparam int unsigned IN_PRIO_W = 8;
    localparam int unsigned OCC_W = 5;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_PEEK    = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [VALUE_W-1:0] value;
    } cell_ctrl_t;

endpackage

@@ sv/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: command decode, entry count, result register.
// Depends on spq_pkg and spq_cell.
//
//  channel | direction | tdata (low bit up)                    | tuser
//  s_      | in        | item_value[15:0], item_priority[23:16] | command[1:0]
//  m_      | out       | head_value[15:0], head_priority[23:16],| status[1:0]
//          |           | occupancy[28:24]                      |
//
// The whole cell chain updates at the edge that accepts a command.
// A new transfer is accepted each cycle while the result register is empty or being read.
// The result is registered when the transfer is accepted and holds while m_tready is low.
// Reset empties the queue at once; no clearing pass is needed.
module sorted_priority_queue import spq_pkg::*; #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned PRIORITY_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // item_value[15:0], item_priority[23:16]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // head_value[15:0], head_priority[23:16], occupancy[28:24]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned PB = PRIORITY_BITS;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_valid_reg;
    status_t              status_reg;
    status_t              status_next;
    logic [VALUE_W-1:0]   head_value_reg;
    logic [VALUE_W-1:0]   head_value_next;
    logic [IN_PRIO_W-1:0] head_prio_reg;
    logic [IN_PRIO_W-1:0] head_prio_next;
    logic [OCC_W-1:0]     occ_reg;
    logic [OCC_W-1:0]     occ_next;

    logic                 accept;
    cmd_t                 cmd;
    cell_ctrl_t           ctrl;
    logic [PB-1:0]        new_prio;
    logic [IN_PRIO_W-1:0] head_prio_ext;

    logic                 cell_ge    [DEPTH];
    logic [VALUE_W-1:0]   cell_value [DEPTH];
    logic [PB-1:0]        cell_prio  [DEPTH];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);

    generate
        if (PB <= IN_PRIO_W) begin : g_prio_narrow
            assign new_prio      = s_tdata[16 +: PB];
            assign head_prio_ext = IN_PRIO_W'(cell_prio[0]);
        end else begin : g_prio_wide
            assign new_prio      = PB'(s_tdata[23:16]);
            assign head_prio_ext = cell_prio[0][IN_PRIO_W-1:0];
        end
        if (CNT_W <= OCC_W) begin : g_occ_narrow
            assign occ_next = OCC_W'(count_next);
        end else begin : g_occ_wide
            assign occ_next = count_next[OCC_W-1:0];
        end
    endgenerate

    always_comb begin
        ctrl.op         = CELL_HOLD;
        ctrl.value      = s_tdata[15:0];
        status_next     = ST_OK;
        head_value_next = '0;
        head_prio_next  = '0;
        count_next      = count_reg;
        if (accept) begin
            case (cmd)
                CMD_ENQUEUE: begin
                    if (count_reg == CNT_W'(DEPTH)) begin
                        status_next = ST_FULL;
                    end else begin
                        ctrl.op    = CELL_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_DEQUEUE: begin
                    if (count_reg == '0) begin
                        status_next = ST_EMPTY;
                    end else begin
                        ctrl.op         = CELL_SHIFT;
                        head_value_next = cell_value[0];
                        head_prio_next  = head_prio_ext;
                        count_next      = count_reg - CNT_W'(1);
                    end
                end
                CMD_PEEK: begin
                    if (count_reg == '0) begin
                        status_next = ST_EMPTY;
                    end else begin
                        head_value_next = cell_value[0];
                        head_prio_next  = head_prio_ext;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic               prev_ge;
            logic [VALUE_W-1:0] prev_value;
            logic [PB-1:0]      prev_prio;
            logic [VALUE_W-1:0] next_value;
            logic [PB-1:0]      next_prio;

            if (gi == 0) begin : g_first
                assign prev_ge    = 1'b1;
                assign prev_value = s_tdata[15:0];
                assign prev_prio  = new_prio;
            end else begin : g_inner
                assign prev_ge    = cell_ge[gi-1];
                assign prev_value = cell_value[gi-1];
                assign prev_prio  = cell_prio[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign next_value = '0;
                assign next_prio  = '0;
            end else begin : g_mid
                assign next_value = cell_value[gi+1];
                assign next_prio  = cell_prio[gi+1];
            end

            spq_cell #(
                .INDEX (gi),
                .CNT_W (CNT_W),
                .PRIO_W(PB)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .new_prio  (new_prio),
                .count     (count_reg),
                .prev_ge   (prev_ge),
                .prev_value(prev_value),
                .prev_prio (prev_prio),
                .next_value(next_value),
                .next_prio (next_prio),
                .ge        (cell_ge[gi]),
                .value     (cell_value[gi]),
                .prio      (cell_prio[gi])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            status_reg     <= status_next;
            head_value_reg <= head_value_next;
            head_prio_reg  <= head_prio_next;
            occ_reg        <= occ_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, occ_reg, head_prio_reg, head_value_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_full_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd == CMD_ENQUEUE && count_reg == CNT_W'(DEPTH)
        |=> m_tvalid && m_tuser == ST_FULL && count_reg == CNT_W'(DEPTH))
        else $error("Enqueue on a full queue was not refused.");

    a_dequeue_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd == CMD_DEQUEUE && count_reg != '0
        |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("Dequeue did not remove exactly one entry.");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[23:0] == '0)
        else $error("Empty status carries a nonzero head entry.");
`endif

endmodule

@@ sv/spq_cell.sv @@
// One storage cell of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CNT_W = 5,
    parameter int unsigned PRIO_W = 8
) (
    input  logic               aclk,
    input  cell_ctrl_t         ctrl,
    input  logic [PRIO_W-1:0]  new_prio,
    input  logic [CNT_W-1:0]   count,
    input  logic               prev_ge,
    input  logic [VALUE_W-1:0] prev_value,
    input  logic [PRIO_W-1:0]  prev_prio,
    input  logic [VALUE_W-1:0] next_value,
    input  logic [PRIO_W-1:0]  next_prio,
    output logic               ge,
    output logic [VALUE_W-1:0] value,
    output logic [PRIO_W-1:0]  prio
);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic [PRIO_W-1:0]  prio_reg;
    logic [PRIO_W-1:0]  prio_next;

    // An occupied cell whose priority is at least the new one keeps its place.
    assign ge = (CNT_W'(INDEX) < count) && (prio_reg >= new_prio);

    always_comb begin
        value_next = value_reg;
        prio_next  = prio_reg;
        case (ctrl.op)
            CELL_INSERT: begin
                if (!ge) begin
                    if (prev_ge) begin
                        value_next = ctrl.value;
                        prio_next  = new_prio;
                    end else begin
                        value_next = prev_value;
                        prio_next  = prev_prio;
                    end
                end
            end
            CELL_SHIFT: begin
                value_next = next_value;
                prio_next  = next_prio;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

@@ dv/tb_sorted_priority_queue.sv @@
// Self-checking testbench for sorted_priority_queue: directed cases, then random traffic.
// Predicts every result with its own sorted-list model and checks each m_ transfer in order.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int DEPTH = 16;
    localparam int PRIORITY_BITS = 8;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        status_t     status;
        logic [15:0] value;
        logic [7:0]  prio;
        logic [4:0]  occ;
    } head_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    logic [15:0] queue_values [DEPTH];
    logic [7:0]  queue_prios [DEPTH];
    int          queue_count = 0;
    head_result_t pending_heads [$];

    int error_count = 0;
    int mismatch_count = 0;
    int burst_left = 0;
    int rx_mode = 0;
    int rx_left = 0;
    int enq_count = 0;
    int deq_count = 0;
    int peek_count = 0;
    int unused_count = 0;
    int full_count = 0;
    int empty_count = 0;
    int deepest = 0;

    sorted_priority_queue #(
        .DEPTH(DEPTH),
        .PRIORITY_BITS(PRIORITY_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic head_result_t predict_queue_op(input logic [1:0] cmd,
                                                      input logic [15:0] val,
                                                      input logic [7:0] prio);
        head_result_t r;
        int pos;
        r.status = ST_OK;
        r.value = '0;
        r.prio = '0;
        if (cmd == CMD_ENQUEUE) begin
            if (queue_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < queue_count && queue_prios[pos] >= prio)
                    pos++;
                for (int i = queue_count; i > pos; i--) begin
                    queue_values[i] = queue_values[i-1];
                    queue_prios[i] = queue_prios[i-1];
                end
                queue_values[pos] = val;
                queue_prios[pos] = prio;
                queue_count++;
            end
        end else if (cmd == CMD_DEQUEUE || cmd == CMD_PEEK) begin
            if (queue_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.value = queue_values[0];
                r.prio = queue_prios[0];
                if (cmd == CMD_DEQUEUE) begin
                    for (int i = 1; i < queue_count; i++) begin
                        queue_values[i-1] = queue_values[i];
                        queue_prios[i-1] = queue_prios[i];
                    end
                    queue_count--;
                end
            end
        end
        r.occ = 5'(queue_count);
        return r;
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [15:0] val,
                             input logic [7:0] prio);
        head_result_t r;
        s_tvalid <= 1'b1;
        s_tdata <= {prio, val};
        s_tuser <= cmd;
        do @(posedge aclk); while (!s_tready);
        r = predict_queue_op(cmd, val, prio);
        pending_heads.push_back(r);
        case (cmd)
            CMD_ENQUEUE: enq_count++;
            CMD_DEQUEUE: deq_count++;
            CMD_PEEK:    peek_count++;
            default:     unused_count++;
        endcase
        if (r.status == ST_FULL) full_count++;
        if (r.status == ST_EMPTY) empty_count++;
        if (queue_count > deepest) deepest = queue_count;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 15);
        end
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (pending_heads.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(16, 96);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= (rx_left % 5) < 2;
        endcase
    end

    always @(posedge aclk) begin
        head_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_heads.size() == 0) begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("Unexpected result: status %0d data %h", m_tuser, m_tdata);
            end else begin
                want = pending_heads.pop_front();
                if (m_tuser !== want.status || m_tdata[15:0] !== want.value ||
                    m_tdata[23:16] !== want.prio || m_tdata[28:24] !== want.occ) begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("Mismatch: expected st %0d val %h pri %h occ %0d",
                                 want.status, want.value, want.prio, want.occ);
                        $display("          got      st %0d val %h pri %h occ %0d",
                                 m_tuser, m_tdata[15:0], m_tdata[23:16], m_tdata[28:24]);
                    end
                end
            end
        end
    end

    task automatic test_empty_reads();
        send_item(CMD_DEQUEUE, 16'h1234, 8'h56);
        send_item(CMD_PEEK, 16'hFFFF, 8'hFF);
        send_item(CMD_UNUSED, 16'hFFFF, 8'hFF);
    endtask

    task automatic test_extremes_and_ties();
        send_item(CMD_ENQUEUE, 16'h7FFF, 8'hFF);
        send_item(CMD_ENQUEUE, 16'h8000, 8'h00);
        send_item(CMD_ENQUEUE, 16'h5555, 8'hFF);
        send_item(CMD_ENQUEUE, 16'hAAAA, 8'h00);
        send_item(CMD_PEEK, 16'h0000, 8'h00);
        send_item(CMD_UNUSED, 16'h0000, 8'h00);
        send_item(CMD_DEQUEUE, 16'h0000, 8'h00);
        send_item(CMD_DEQUEUE, 16'h0000, 8'h00);
    endtask

    task automatic test_fill_and_overflow();
        for (int i = 0; i < DEPTH - 2; i++)
            send_item(CMD_ENQUEUE, 16'(i * 16'h1111), 8'(8'h40 + (i % 3) * 8'h40));
        send_item(CMD_ENQUEUE, 16'hFFFF, 8'hFF);
        send_item(CMD_PEEK, 16'h0000, 8'h00);
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int mode;
        int mode_left;
        int pick;
        logic [1:0]  cmd;
        logic [15:0] val;
        logic [7:0]  prio;
        sent = 0;
        mode = 0;
        mode_left = 0;
        while (sent < n_items) begin
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(8, 40);
            end
            mode_left--;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                cmd = CMD_UNUSED;
            else if (pick < 13)
                cmd = CMD_PEEK;
            else if (mode == 0)
                cmd = (pick < 78) ? CMD_ENQUEUE : CMD_DEQUEUE;
            else if (mode == 1)
                cmd = (pick < 35) ? CMD_ENQUEUE : CMD_DEQUEUE;
            else
                cmd = (pick < 56) ? CMD_ENQUEUE : CMD_DEQUEUE;
            val = 16'($urandom);
            case ($urandom_range(0, 3))
                0: prio = 8'($urandom_range(0, 3));
                1: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default: prio = 8'($urandom);
            endcase
            send_item(cmd, val, prio);
            sent++;
            if (sent == n_items / 2)
                pause_until_drained();
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_reads();
        test_extremes_and_ties();
        test_fill_and_overflow();
        test_random_traffic(720);
        pause_until_drained();
        repeat (10) @(posedge aclk);
        if (pending_heads.size() != 0)
            error_count++;
        $display("Sent %0d enqueue, %0d dequeue, %0d peek and %0d unused-code transfers.",
                 enq_count, deq_count, peek_count, unused_count);
        $display("Saw %0d full refusals, %0d empty reads, deepest occupancy %0d.",
                 full_count, empty_count, deepest);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
